>>> sv/ilt_pkg.sv
// Shared types and constants for the indexed list table.
// Holds request, status and sequencer codes; used by the top level and its checker.
`timescale 1ns / 1ps

package ilt_pkg;

  localparam int ILT_DEPTH = 64;
  localparam int REQ_W     = 3;
  localparam int POS_W     = 7;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 7;
  localparam int ST_W      = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_INSERT    = 3'd1,
    REQ_OVERWRITE = 3'd2,
    REQ_READ      = 3'd3,
    REQ_REMOVE    = 3'd4
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_READ_WAIT,
    S_FINISH
  } state_t;

endpackage

>>> sv/indexed_list_table.sv
// Indexed list table: ordered list of signed words in a single-port-write memory.
// Depends on ilt_pkg for request, status and sequencer codes.
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit words with append, insert, overwrite,
// read and remove at an index; each request item returns one result item with the
// value read, the count after the request and a status. The block takes one request
// at a time. A request passes from S_IDLE through S_EXEC to S_FINISH for append,
// overwrite and any rejected request; an in-range read adds S_READ_WAIT, an insert
// that moves entries up adds an S_SHIFT_RD/S_SHIFT_WR pair per moved entry and S_PUT,
// and a remove that moves entries down adds one such pair per moved entry.
// The result register loads in S_FINISH, or later while the previous result is still
// stalled. The entry memory moves each entry with a read and then a write, which sets
// the cost of insert and remove. The result register frees the input side: a new
// request is taken while the previous result still waits to be taken.
// No clearing pass after reset; entries beyond the count are never read.
module indexed_list_table #(
  parameter int DEPTH = ilt_pkg::ILT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ilt_pkg::REQ_W-1:0]         req_type,
  input  logic [ilt_pkg::POS_W-1:0]         position,
  input  logic signed [ilt_pkg::VAL_W-1:0]  item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ilt_pkg::VAL_W-1:0]  read_value,
  output logic [ilt_pkg::CNT_W-1:0]         entry_count,
  output logic [ilt_pkg::ST_W-1:0]          status
);
  import ilt_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 2;

  state_t state, state_next;

  logic [CW-1:0]           count, count_next;
  logic [AW-1:0]           cursor, cursor_next;
  req_t                    kind, kind_next;
  logic [POS_W-1:0]        pos, pos_next;
  logic signed [VAL_W-1:0] val, val_next;
  logic signed [VAL_W-1:0] res_value, res_value_next;
  status_t                 res_status, res_status_next;

  logic                    out_valid_next;
  logic signed [VAL_W-1:0] read_value_next;
  logic [CNT_W-1:0]        entry_count_next;
  logic [ST_W-1:0]         status_next;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [AW-1:0]           mem_raddr;
  logic signed [VAL_W-1:0] mem_wdata;

  logic [CMPW-1:0]         pos_ext;
  logic [CMPW-1:0]         cnt_ext;
  logic                    is_full;

  assign pos_ext  = CMPW'(pos);
  assign cnt_ext  = CMPW'(count);
  assign is_full  = cnt_ext >= CMPW'(DEPTH);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cursor      <= cursor_next;
    kind        <= kind_next;
    pos         <= pos_next;
    val         <= val_next;
    res_value   <= res_value_next;
    res_status  <= res_status_next;
    read_value  <= read_value_next;
    entry_count <= entry_count_next;
    status      <= status_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    cursor_next      = cursor;
    kind_next        = kind;
    pos_next         = pos;
    val_next         = val;
    res_value_next   = res_value;
    res_status_next  = res_status;
    out_valid_next   = out_valid && out_stall;
    read_value_next  = read_value;
    entry_count_next = entry_count;
    status_next      = status;
    mem_we           = 1'b0;
    mem_waddr        = cursor;
    mem_wdata        = val;
    mem_raddr        = cursor;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_next  = req_t'(req_type);
          pos_next   = position;
          val_next   = item_value;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_value_next  = '0;
        res_status_next = ST_OK;
        state_next      = S_FINISH;
        case (kind)
          REQ_APPEND: begin
            if (is_full) begin
              res_status_next = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = AW'(count);
              count_next = count + CW'(1);
            end
          end
          REQ_INSERT: begin
            if (pos_ext > cnt_ext) begin
              res_status_next = ST_RANGE;
            end else if (is_full) begin
              res_status_next = ST_FULL;
            end else if (pos_ext == cnt_ext) begin
              mem_we     = 1'b1;
              mem_waddr  = AW'(pos);
              count_next = count + CW'(1);
            end else begin
              cursor_next = AW'(count);
              state_next  = S_SHIFT_RD;
            end
          end
          REQ_OVERWRITE: begin
            if (pos_ext >= cnt_ext) begin
              res_status_next = ST_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pos);
            end
          end
          REQ_READ: begin
            if (pos_ext >= cnt_ext) begin
              res_status_next = ST_RANGE;
              res_value_next  = '1;
            end else begin
              mem_raddr  = AW'(pos);
              state_next = S_READ_WAIT;
            end
          end
          REQ_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
              res_status_next = ST_RANGE;
            end else if (pos_ext + CMPW'(1) < cnt_ext) begin
              cursor_next = AW'(pos);
              state_next  = S_SHIFT_RD;
            end else begin
              count_next = count - CW'(1);
            end
          end
          default: ;
        endcase
      end
      S_SHIFT_RD: begin
        mem_raddr  = (kind == REQ_INSERT) ? (cursor - AW'(1)) : (cursor + AW'(1));
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cursor;
        mem_wdata = rdata;
        if (kind == REQ_INSERT) begin
          cursor_next = cursor - AW'(1);
          state_next  = ((cursor - AW'(1)) == AW'(pos)) ? S_PUT : S_SHIFT_RD;
        end else if (CMPW'(cursor) + CMPW'(2) < cnt_ext) begin
          cursor_next = cursor + AW'(1);
          state_next  = S_SHIFT_RD;
        end else begin
          count_next = count - CW'(1);
          state_next = S_FINISH;
        end
      end
      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(pos);
        count_next = count + CW'(1);
        state_next = S_FINISH;
      end
      S_READ_WAIT: begin
        res_value_next = rdata;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_valid_next   = 1'b1;
          read_value_next  = res_value;
          entry_count_next = CNT_W'(count);
          status_next      = res_status;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/ilt_checker.sv
// Port-level checker for the indexed list table, bound to the top level.
// Depends on ilt_pkg for status codes and field widths.
`timescale 1ns / 1ps

module ilt_checker #(
  parameter int DEPTH = ilt_pkg::ILT_DEPTH
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [ilt_pkg::REQ_W-1:0]         req_type,
  input logic [ilt_pkg::POS_W-1:0]         position,
  input logic signed [ilt_pkg::VAL_W-1:0]  item_value,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [ilt_pkg::VAL_W-1:0]  read_value,
  input logic [ilt_pkg::CNT_W-1:0]         entry_count,
  input logic [ilt_pkg::ST_W-1:0]          status
);
  import ilt_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input side not busy after an item was taken");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == CNT_W'(DEPTH))
    else $error("full status with a count below depth");

  a_range_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RANGE |-> read_value == '1 || read_value == '0)
    else $error("out-of-range result carries an entry value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_RANGE || status == ST_FULL)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value) &&
      $stable(entry_count) && $stable(status))
    else $error("stalled result changed");

endmodule

bind indexed_list_table ilt_checker #(.DEPTH(DEPTH)) u_ilt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .req_type    (req_type),
  .position    (position),
  .item_value  (item_value),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .read_value  (read_value),
  .entry_count (entry_count),
  .status      (status)
);
